// ----- sv/brl_pkg.sv -----
// Shared types, constants and helpers of the byte repeat limiter.
package brl_pkg;

  localparam int unsigned CHAR_BITS   = 8;
  localparam int unsigned PORT_CODE_W = 8;
  localparam int unsigned NUM_CODES   = 1 << CHAR_BITS;
  localparam int unsigned MAP_W       = 64;
  localparam int unsigned NUM_MAPS    = 4;
  localparam int unsigned MAP_SEL_W   = $clog2(NUM_MAPS);
  localparam int unsigned BIT_SEL_W   = $clog2(MAP_W);
  localparam int unsigned MAX_REP_W   = 8;
  localparam int unsigned RUN_W       = 9;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RUN_W-1:0]     RUN_MAX          = '1;
  localparam logic [MAX_REP_W-1:0] MAX_REPEAT_RESET = 8'd3;
  localparam logic [MAP_W-1:0]     EXEMPT_LOW_RESET = 64'h03FF_0000_0000_0000;

  typedef logic [CHAR_BITS-1:0] code_t;
  typedef logic [COUNT_W-1:0]   count_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_REPEAT      = 3'd0,
    REG_EXEMPT_LOW      = 3'd1,
    REG_EXEMPT_MID_LOW  = 3'd2,
    REG_EXEMPT_MID_HIGH = 3'd3,
    REG_EXEMPT_HIGH     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [MAX_REP_W-1:0]                max_repeat;
    logic [NUM_MAPS-1:0][MAP_W-1:0]      exempt_map;
  } cfg_t;

  // One classified byte on its way to the histogram stage
  typedef struct packed {
    code_t code;
    logic  keep;
  } item_t;

  function automatic count_t sat_inc(count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

endpackage

// ----- sv/byte_repeat_limiter_with_drop_counts.sv -----
// Top level of the byte repeat limiter: config registers, front end, queue, back end.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------------
//   in       | in_valid_i / in_stall_o   | char_code_i, starts_string_i
//   out      | out_valid_o / out_stall_i | out_code_o, keep_o, drop_total_o
//   cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte per cycle when not stalled; the histogram RAM takes one read and one write
// per cycle, and a write-to-read forwarding register covers back-to-back hits.
// A result passes through the queue, histogram stage and output register.
// Reset clears the histogram at once through per-entry valid bits; no clearing pass.
// An output stall fills the queue first, then the full queue stalls the input.
module byte_repeat_limiter_with_drop_counts (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [brl_pkg::PORT_CODE_W-1:0] char_code_i,
  input  logic                            starts_string_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [brl_pkg::PORT_CODE_W-1:0] out_code_o,
  output logic                            keep_o,
  output logic [brl_pkg::COUNT_W-1:0]     drop_total_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [brl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [brl_pkg::MAP_W-1:0]       cfg_data_i
);
  import brl_pkg::*;

  cfg_t   cfg_q;
  logic   q_full;
  logic   q_push;
  item_t  q_push_item;
  logic   q_pop;
  logic   q_valid;
  item_t  q_head;
  code_t  out_code;

  assign cfg_ready_o = 1'b1;

  // Ignore writes to indexes beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_repeat <= MAX_REPEAT_RESET;
      cfg_q.exempt_map <= {{((NUM_MAPS - 1) * MAP_W){1'b0}}, EXEMPT_LOW_RESET};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MAX_REPEAT:      cfg_q.max_repeat    <= cfg_data_i[MAX_REP_W-1:0];
        REG_EXEMPT_LOW:      cfg_q.exempt_map[0] <= cfg_data_i;
        REG_EXEMPT_MID_LOW:  cfg_q.exempt_map[1] <= cfg_data_i;
        REG_EXEMPT_MID_HIGH: cfg_q.exempt_map[2] <= cfg_data_i;
        REG_EXEMPT_HIGH:     cfg_q.exempt_map[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  brl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_code_i     (char_code_i),
    .starts_string_i (starts_string_i),
    .cfg_i           (cfg_q),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_push_item)
  );

  brl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  brl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_code_o  (out_code),
    .out_keep_o  (keep_o),
    .out_total_o (drop_total_o)
  );

  assign out_code_o = PORT_CODE_W'(out_code);

endmodule

// ----- sv/brl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module brl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/brl_front.sv -----
// Front end: accepts bytes, tracks the current run and decides keep or drop.
module brl_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [brl_pkg::PORT_CODE_W-1:0]  char_code_i,
  input  logic                             starts_string_i,
  input  brl_pkg::cfg_t                    cfg_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output brl_pkg::item_t                   q_item_o
);
  import brl_pkg::*;

  code_t             last_code_q, last_code_d;
  logic [RUN_W-1:0]  run_count_q, run_count_d;
  code_t             code;
  logic [PORT_CODE_W-1:0] code_ext;
  logic              exempt;
  logic              new_run;
  logic [RUN_W-1:0]  run_inc;
  logic              keep;
  logic              accept;

  assign code     = char_code_i[CHAR_BITS-1:0];
  assign code_ext = PORT_CODE_W'(code);
  assign exempt   = cfg_i.exempt_map[code_ext[BIT_SEL_W +: MAP_SEL_W]][code_ext[BIT_SEL_W-1:0]];
  assign new_run  = starts_string_i || (code != last_code_q) || exempt;
  assign run_inc  = (run_count_q == RUN_MAX) ? run_count_q : run_count_q + RUN_W'(1);
  assign keep     = new_run || (run_inc <= RUN_W'(cfg_i.max_repeat));

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;
  assign q_item_o   = '{code: code, keep: keep};

  always_comb begin
    last_code_d = last_code_q;
    run_count_d = run_count_q;
    if (accept) begin
      if (new_run) begin
        last_code_d = code;
        run_count_d = RUN_W'(1);
      end else begin
        run_count_d = run_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_code_q <= '0;
      run_count_q <= '0;
    end else begin
      last_code_q <= last_code_d;
      run_count_q <= run_count_d;
    end
  end

  a_new_run_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && new_run |=> run_count_q == RUN_W'(1) && last_code_q == $past(code))
    else $error("new run did not restart the run state");

  a_drop_is_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !keep |-> !starts_string_i && code == last_code_q && !exempt)
    else $error("drop decided for a byte that starts a run");

endmodule

// ----- sv/brl_queue.sv -----
// Short queue between the classifier and the histogram stage.
module brl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  brl_pkg::item_t  push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output brl_pkg::item_t  head_o
);
  import brl_pkg::*;

  item_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ----- sv/brl_back.sv -----
// Back end: histogram read-modify-write with forwarding and the output register.
module brl_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  brl_pkg::item_t                q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output brl_pkg::code_t                out_code_o,
  output logic                          out_keep_o,
  output brl_pkg::count_t               out_total_o
);
  import brl_pkg::*;

  // Histogram stage holding the item whose count is being updated
  logic                  b2_valid_q;
  item_t                 b2_item_q;
  logic [NUM_CODES-1:0]  cnt_valid_q;
  logic                  fwd_valid_q;
  code_t                 fwd_code_q;
  count_t                fwd_data_q;
  logic                  out_valid_q;
  code_t                 out_code_q;
  logic                  out_keep_q;
  count_t                out_total_q;

  logic    advance;
  logic    issue;
  logic    we;
  count_t  rdata;
  count_t  cur;
  count_t  next_count;

  assign advance = b2_valid_q && (!out_valid_q || !out_stall_i);
  assign issue   = q_valid_i && (!b2_valid_q || advance);
  assign q_pop_o = issue;
  assign we      = advance && !b2_item_q.keep;

  brl_ram #(
    .Width (COUNT_W),
    .Depth (NUM_CODES)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (b2_item_q.code),
    .wdata_i (next_count),
    .re_i    (issue),
    .raddr_i (q_item_i.code),
    .rdata_o (rdata)
  );

  // Take the latest write when it hits the same byte; unwritten entries read zero
  always_comb begin
    if (fwd_valid_q && (fwd_code_q == b2_item_q.code)) begin
      cur = fwd_data_q;
    end else if (cnt_valid_q[b2_item_q.code]) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
  end

  assign next_count = sat_inc(cur);

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b2_item_q <= q_item_i;
    end
    if (we) begin
      fwd_code_q <= b2_item_q.code;
      fwd_data_q <= next_count;
    end
    if (advance) begin
      out_code_q  <= b2_item_q.code;
      out_keep_q  <= b2_item_q.keep;
      out_total_q <= b2_item_q.keep ? cur : next_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q  <= 1'b0;
      cnt_valid_q <= '0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        b2_valid_q <= 1'b1;
      end else if (advance) begin
        b2_valid_q <= 1'b0;
      end
      if (we) begin
        cnt_valid_q[b2_item_q.code] <= 1'b1;
        fwd_valid_q                 <= 1'b1;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;
  assign out_keep_o  = out_keep_q;
  assign out_total_o = out_total_q;

  a_write_marks_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> cnt_valid_q[$past(b2_item_q.code)] && fwd_code_q == $past(b2_item_q.code))
    else $error("histogram write not recorded");

  a_issue_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> b2_valid_q)
    else $error("issued item lost before the histogram stage");

  a_advance_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("finished item did not reach the output register");

  a_drop_counts_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !b2_item_q.keep |=> out_total_q != '0)
    else $error("dropped byte reported a zero count");

endmodule

// ----- dv/brl_checker.sv -----
// Scoreboard for the byte repeat limiter: mirrors its state and checks every result.
module brl_checker
  import brl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [PORT_CODE_W-1:0] char_code_i,
  input  logic                   starts_string_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [PORT_CODE_W-1:0] out_code_i,
  input  logic                   keep_i,
  input  logic [COUNT_W-1:0]     drop_total_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [MAP_W-1:0]       cfg_data_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o,
  output int unsigned            checked_o,
  output int unsigned            dropped_o
);

  typedef struct packed {
    logic [PORT_CODE_W-1:0] code;
    logic                   keep;
    count_t                 total;
  } byte_verdict_t;

  logic [MAX_REP_W-1:0] max_repeat_q;
  logic [MAP_W-1:0]     exempt_q [NUM_MAPS];
  code_t                prev_code_q;
  logic [RUN_W-1:0]     run_len_q;
  count_t               drops_q [NUM_CODES];
  byte_verdict_t        verdict_q [$];
  byte_verdict_t        want;
  int unsigned          errors;
  int unsigned          results;
  int unsigned          drops_seen;

  // Advance the mirrored run state by one byte and return what the block must report
  function automatic byte_verdict_t limit_byte(input logic [PORT_CODE_W-1:0] raw,
                                               input logic first);
    code_t         code;
    logic          exempt_hit;
    byte_verdict_t v;
    code       = raw[CHAR_BITS-1:0];
    exempt_hit = exempt_q[code / MAP_W][code % MAP_W];
    v.code     = PORT_CODE_W'(code);
    if (first || code != prev_code_q || exempt_hit) begin
      prev_code_q = code;
      run_len_q   = RUN_W'(1);
      v.keep      = 1'b1;
    end else begin
      if (run_len_q != RUN_MAX) run_len_q = run_len_q + 1'b1;
      v.keep = (run_len_q <= max_repeat_q);
      if (!v.keep && drops_q[code] != '1) drops_q[code] = drops_q[code] + 1'b1;
    end
    v.total = drops_q[code];
    return v;
  endfunction

  task automatic note_mismatch(input string field, input logic [COUNT_W-1:0] exp_v,
                               input logic [COUNT_W-1:0] got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_repeat_q = MAX_REPEAT_RESET;
      exempt_q[0] = EXEMPT_LOW_RESET;
      for (int m = 1; m < NUM_MAPS; m++) exempt_q[m] = '0;
      prev_code_q = '0;
      run_len_q   = '0;
      foreach (drops_q[c]) drops_q[c] = '0;
      verdict_q.delete();
      errors      = 0;
      results     = 0;
      drops_seen  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      dropped_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAX_REPEAT:      max_repeat_q = cfg_data_i[MAX_REP_W-1:0];
          REG_EXEMPT_LOW:      exempt_q[0]  = cfg_data_i;
          REG_EXEMPT_MID_LOW:  exempt_q[1]  = cfg_data_i;
          REG_EXEMPT_MID_HIGH: exempt_q[2]  = cfg_data_i;
          REG_EXEMPT_HIGH:     exempt_q[3]  = cfg_data_i;
          default: ;  // unused index: drop the write
        endcase
      end
      if (in_valid_i && !in_stall_i)
        verdict_q.push_back(limit_byte(char_code_i, starts_string_i));
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (!keep_i) drops_seen++;
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending, expected none, got code %0h keep %b",
                   $time, out_code_i, keep_i);
          $display("%0t: unexpected result total %0h", $time, drop_total_i);
        end else begin
          want = verdict_q.pop_front();
          if (out_code_i !== want.code)
            note_mismatch("out_code", COUNT_W'(want.code), COUNT_W'(out_code_i));
          if (keep_i !== want.keep)
            note_mismatch("keep", COUNT_W'(want.keep), COUNT_W'(keep_i));
          if (drop_total_i !== want.total)
            note_mismatch("drop_total", want.total, drop_total_i);
        end
      end
      fail_count_o <= errors;
      pending_o    <= unsigned'(verdict_q.size());
      checked_o    <= results;
      dropped_o    <= drops_seen;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top of the byte repeat limiter: clock, reset, stimulus, output stalls, verdict.
module tb_top;
  import brl_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned LONG_RUN        = 520;
  localparam int unsigned RANDOM_SETTINGS = 4;
  localparam int unsigned PALETTE_SIZE    = 4;
  localparam logic [PORT_CODE_W-1:0] DIGIT_ZERO  = 8'h30;
  localparam logic [PORT_CODE_W-1:0] DIGIT_SEVEN = 8'h37;
  localparam logic [PORT_CODE_W-1:0] LETTER_A    = 8'h41;
  localparam logic [PORT_CODE_W-1:0] HIGH_CODE   = 8'h80;
  localparam logic [MAP_W-1:0]       MAP_NONE    = '0;
  localparam logic [MAP_W-1:0]       MAP_ALL     = '1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [PORT_CODE_W-1:0] char_code = '0;
  logic                   starts_string = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [PORT_CODE_W-1:0] out_code;
  logic                   keep;
  count_t                 drop_total;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [MAP_W-1:0]       cfg_data = '0;

  int unsigned            fail_count;
  int unsigned            pending;
  int unsigned            checked;
  int unsigned            dropped;
  bit                     steady = 1'b0;
  int unsigned            stall_left;
  int unsigned            quiet_cycles = 0;
  int unsigned            bytes_sent = 0;
  int unsigned            settings_used = 0;
  logic [PORT_CODE_W-1:0] palette [PALETTE_SIZE];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  byte_repeat_limiter_with_drop_counts i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .char_code_i    (char_code),
    .starts_string_i(starts_string),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_code_o     (out_code),
    .keep_o         (keep),
    .drop_total_o   (drop_total),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  brl_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .char_code_i    (char_code),
    .starts_string_i(starts_string),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_code_i     (out_code),
    .keep_i         (keep),
    .drop_total_i   (drop_total),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .dropped_o      (dropped)
  );

  // Stall the output at random after each transaction, except in steady mode
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      stall_left = steady ? 0 : $urandom_range(0, 7);
      out_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[byte_repeat_limiter_with_drop_counts] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [MAX_REP_W-1:0] max_rep,
                               input logic [MAP_W-1:0] map_low, input logic [MAP_W-1:0] map_mlo,
                               input logic [MAP_W-1:0] map_mhi, input logic [MAP_W-1:0] map_high);
    write_reg(REG_MAX_REPEAT, MAP_W'(max_rep));
    write_reg(REG_EXEMPT_LOW, map_low);
    write_reg(REG_EXEMPT_MID_LOW, map_mlo);
    write_reg(REG_EXEMPT_MID_HIGH, map_mhi);
    write_reg(REG_EXEMPT_HIGH, map_high);
    settings_used++;
  endtask

  task automatic send_byte(input logic [PORT_CODE_W-1:0] code, input logic first);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    char_code     <= code;
    starts_string <= first;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Stop sending and hold until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [PORT_CODE_W-1:0] pick_code();
    case ($urandom_range(0, 3))
      0, 1:    return palette[$urandom_range(0, PALETTE_SIZE - 1)];
      2:       return DIGIT_ZERO + PORT_CODE_W'($urandom_range(0, 9));
      default: return PORT_CODE_W'($urandom);
    endcase
  endfunction

  // One string made of runs; now and then break it with a stray start mark
  task automatic send_string();
    int unsigned            n_runs;
    int unsigned            run_len;
    logic                   first;
    logic [PORT_CODE_W-1:0] code;
    n_runs = $urandom_range(1, 6);
    first  = 1'b1;
    for (int r = 0; r < n_runs; r++) begin
      code    = pick_code();
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      for (int k = 0; k < run_len; k++) begin
        send_byte(code, first || ($urandom_range(0, 15) == 0));
        first = 1'b0;
      end
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_byte(PORT_CODE_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned goal;
    goal = bytes_sent + n_items;
    palette[0] = '0;
    palette[1] = '1;
    palette[2] = PORT_CODE_W'($urandom);
    palette[3] = PORT_CODE_W'($urandom);
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      if ($urandom_range(0, 39) == 0) wait_drained();
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_string();
    end
  endtask

  function automatic logic [MAP_W-1:0] sparse_map();
    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: bytes before any string start, digit exemption, start mark on a repeat
    repeat (5) send_byte('0, 1'b0);
    send_byte(LETTER_A, 1'b1);
    repeat (3) send_byte(LETTER_A, 1'b0);
    repeat (5) send_byte(DIGIT_SEVEN, 1'b0);
    send_byte('1, 1'b1);
    repeat (4) send_byte('1, 1'b0);
    send_byte('1, 1'b1);
    send_byte(HIGH_CODE, 1'b0);
    send_byte(HIGH_CODE, 1'b1);
    wait_drained();

    // Zero max_repeat, nothing exempt
    apply_setting('0, MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE);
    run_random(60);
    wait_drained();

    // Everything exempt; unused indexes must leave the setting alone
    apply_setting('1, MAP_ALL, MAP_ALL, MAP_ALL, MAP_ALL);
    for (int k = int'(REG_EXEMPT_HIGH) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
    run_random(40);
    wait_drained();

    // One run long enough to saturate the run length
    apply_setting('1, MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE);
    send_byte(LETTER_A, 1'b1);
    repeat (LONG_RUN - 1) send_byte(LETTER_A, 1'b0);
    run_random(30);
    wait_drained();

    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      apply_setting((s == RANDOM_SETTINGS - 1) ? MAX_REP_W'($urandom_range(0, 255))
                                               : MAX_REP_W'($urandom_range(0, 6)),
                    sparse_map(), sparse_map(), sparse_map(), sparse_map());
      run_random(45);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d bytes, %0d of them dropped, under %0d register settings",
             checked, dropped, settings_used);
    $display("Settings spanned zero and full max_repeat, empty and full exempt maps, run saturation");
    if (fail_count == 0 && pending == 0) begin
      $display("[byte_repeat_limiter_with_drop_counts] OK");
    end else begin
      $display("[byte_repeat_limiter_with_drop_counts] ERROR");
    end
    $finish;
  end

endmodule
